// ----- src/bgc_pkg.sv -----
// ----------------------------------------------------------------------------
// bgc_pkg: shared types and constants for the button gesture classifier
// Timer width, register indexes, reset values and the tick result record.
// ----------------------------------------------------------------------------
package bgc_pkg;

   localparam int TIMER_BITS = 16;
   localparam int CFG_W      = 16;
   localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
   localparam int CSR_IDX_W  = 3;

   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CLICK_GAP  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_PRESS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAUGE_HOLD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GAUGE_LINGER = 3'd4;

   localparam logic [CFG_W-1:0] RST_DEBOUNCE     = 16'd25;
   localparam logic [CFG_W-1:0] RST_CLICK_GAP    = 16'd350;
   localparam logic [CFG_W-1:0] RST_LONG_PRESS   = 16'd600;
   localparam logic [CFG_W-1:0] RST_GAUGE_HOLD   = 16'd5000;
   localparam logic [CFG_W-1:0] RST_GAUGE_LINGER = 16'd4000;

   localparam logic [1:0] ACT_NONE = 2'd0;
   localparam logic [1:0] ACT_PLAY = 2'd1;
   localparam logic [1:0] ACT_NEXT = 2'd2;
   localparam logic [1:0] ACT_PREV = 2'd3;

   localparam logic [1:0] CLICKS_MAX = 2'd3;

   typedef struct packed {
      logic [CFG_W-1:0] debounce_ticks;
      logic [CFG_W-1:0] click_gap_ticks;
      logic [CFG_W-1:0] long_press_ticks;
      logic [CFG_W-1:0] gauge_hold_ticks;
      logic [CFG_W-1:0] gauge_linger_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0] transport_action;
      logic       mute_toggled;
      logic       gauge_read_request;
      logic       activity;
      logic       muted;
      logic       playing;
      logic       gauge_shown;
      logic       pressed;
   } result_type;

endpackage

// ----- src/bgc_if.sv -----
// ----------------------------------------------------------------------------
// bgc_req_if / bgc_rsp_if: request and result channels
// Valid/ready handshake with the tick payload carried alongside.
// ----------------------------------------------------------------------------
interface bgc_req_if;
   logic valid;
   logic ready;
   logic switch_level;
   logic knob_turned;

   modport source (output valid, output switch_level, output knob_turned, input ready);
   modport sink   (input valid, input switch_level, input knob_turned, output ready);
endinterface

interface bgc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] transport_action;
   logic       mute_toggled;
   logic       gauge_read_request;
   logic       activity;
   logic       muted;
   logic       playing;
   logic       gauge_shown;
   logic       pressed;

   modport source (output valid, output transport_action, output mute_toggled,
                   output gauge_read_request, output activity, output muted,
                   output playing, output gauge_shown, output pressed, input ready);
   modport sink   (input valid, input transport_action, input mute_toggled,
                   input gauge_read_request, input activity, input muted,
                   input playing, input gauge_shown, input pressed, output ready);
endinterface

// ----- src/bgc_core.sv -----
// ----------------------------------------------------------------------------
// bgc_core: gesture state and one-tick update
// Debounce, hold timing, click counting, gauge linger and mute/play state.
// ----------------------------------------------------------------------------
module bgc_core
   import bgc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic       switch_level,
   input  logic       knob_turned,
   input  cfg_type    cfg,
   output result_type result
);

   logic                  last_raw_ff, last_raw_in;
   logic                  stable_ff, stable_in;
   logic [TIMER_BITS-1:0] since_change_ff, since_change_in;
   logic [TIMER_BITS-1:0] since_press_ff, since_press_in;
   logic [TIMER_BITS-1:0] since_click_ff, since_click_in;
   logic [1:0]            clicks_ff, clicks_in;
   logic                  armed_ff, armed_in;
   logic [CFG_W-1:0]      remain_ff, remain_in;
   logic                  mute_ff, mute_in;
   logic                  play_ff, play_in;

   logic [1:0] action;
   logic       toggled, request, activity;

   always_comb begin
      last_raw_in     = last_raw_ff;
      stable_in       = stable_ff;
      since_change_in = (since_change_ff == TIMER_MAX) ? TIMER_MAX : since_change_ff + 1'b1;
      since_press_in  = (since_press_ff == TIMER_MAX) ? TIMER_MAX : since_press_ff + 1'b1;
      since_click_in  = (since_click_ff == TIMER_MAX) ? TIMER_MAX : since_click_ff + 1'b1;
      clicks_in       = clicks_ff;
      armed_in        = armed_ff;
      remain_in       = (remain_ff != '0) ? remain_ff - 1'b1 : remain_ff;
      mute_in         = mute_ff;
      play_in         = play_ff;
      action          = ACT_NONE;
      toggled         = 1'b0;
      request         = 1'b0;
      activity        = 1'b0;

      if (knob_turned) begin
         activity = 1'b1;
         mute_in  = 1'b0;
      end

      if (switch_level != last_raw_ff) begin
         last_raw_in     = switch_level;
         since_change_in = '0;
      end

      if (CMP_W'(since_change_in) > CMP_W'(cfg.debounce_ticks) && switch_level != stable_ff) begin
         stable_in = switch_level;
         if (!switch_level) begin
            activity       = 1'b1;
            since_press_in = '0;
            armed_in       = 1'b0;
         end else if (armed_ff) begin
            // release after a gauge hold is swallowed
         end else if (CMP_W'(since_press_in) >= CMP_W'(cfg.long_press_ticks)) begin
            mute_in = ~mute_in;
            toggled = 1'b1;
         end else begin
            if (clicks_ff != CLICKS_MAX) begin
               clicks_in = clicks_ff + 1'b1;
            end
            since_click_in = '0;
         end
      end

      if (!stable_in && CMP_W'(since_press_in) >= CMP_W'(cfg.gauge_hold_ticks)) begin
         if (!armed_in) begin
            armed_in = 1'b1;
            request  = 1'b1;
         end
         remain_in = cfg.gauge_linger_ticks;
         activity  = 1'b1;
      end

      if (clicks_in != '0 && stable_in &&
          CMP_W'(since_click_in) > CMP_W'(cfg.click_gap_ticks)) begin
         case (clicks_in)
            ACT_PLAY: begin
               action  = ACT_PLAY;
               play_in = ~play_ff;
            end
            ACT_NEXT: action = ACT_NEXT;
            default:  action = ACT_PREV;
         endcase
         clicks_in = '0;
      end
   end

   always_comb begin
      result.transport_action   = action;
      result.mute_toggled       = toggled;
      result.gauge_read_request = request;
      result.activity           = activity;
      result.muted              = mute_in;
      result.playing            = play_in;
      result.gauge_shown        = (remain_in != '0);
      result.pressed            = ~stable_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff     <= 1'b1;
         stable_ff       <= 1'b1;
         since_change_ff <= '0;
         since_press_ff  <= '0;
         since_click_ff  <= '0;
         clicks_ff       <= '0;
         armed_ff        <= 1'b0;
         remain_ff       <= '0;
         mute_ff         <= 1'b0;
         play_ff         <= 1'b0;
      end else if (step_en) begin
         last_raw_ff     <= last_raw_in;
         stable_ff       <= stable_in;
         since_change_ff <= since_change_in;
         since_press_ff  <= since_press_in;
         since_click_ff  <= since_click_in;
         clicks_ff       <= clicks_in;
         armed_ff        <= armed_in;
         remain_ff       <= remain_in;
         mute_ff         <= mute_in;
         play_ff         <= play_in;
      end
   end

endmodule

// ----- src/button_gesture_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// button_gesture_classifier_unit: push-switch gesture classifier
// One request per millisecond tick carries the raw active-low switch level
// and a knob-turn flag; one result per request carries the transport action
// (none, play/pause, next, previous), the mute toggle, the gauge read request,
// activity and the current muted, playing, gauge-shown and pressed states.
// The request goes into an input register; the tick update runs between that
// register and the result register. One request is taken per cycle while the
// result side keeps up. When the receiver stalls, the result is held and one
// further request is still taken into the input register; after that ready
// drops until the result is taken. Timing registers are written through
// csr_wr_en, csr_index and csr_wdata; the user must write them only while no
// request is in flight, as the block does not enforce it. Reset (synchronous,
// active high) empties both registers and restores the released switch,
// cleared timers and counters, unmuted, paused and the default timings.
// ----------------------------------------------------------------------------
module button_gesture_classifier_unit
   import bgc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   bgc_req_if.sink              req,
   bgc_rsp_if.source            rsp,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   cfg_type    cfg_ff;
   logic       in_vld_ff;
   logic       in_level_ff;
   logic       in_knob_ff;
   logic       out_vld_ff;
   result_type out_ff;
   result_type result;
   logic       advance;

   assign advance   = in_vld_ff && (!out_vld_ff || rsp.ready);
   assign req.ready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks     <= RST_DEBOUNCE;
         cfg_ff.click_gap_ticks    <= RST_CLICK_GAP;
         cfg_ff.long_press_ticks   <= RST_LONG_PRESS;
         cfg_ff.gauge_hold_ticks   <= RST_GAUGE_HOLD;
         cfg_ff.gauge_linger_ticks <= RST_GAUGE_LINGER;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_DEBOUNCE:     cfg_ff.debounce_ticks     <= csr_wdata;
            REG_CLICK_GAP:    cfg_ff.click_gap_ticks    <= csr_wdata;
            REG_LONG_PRESS:   cfg_ff.long_press_ticks   <= csr_wdata;
            REG_GAUGE_HOLD:   cfg_ff.gauge_hold_ticks   <= csr_wdata;
            REG_GAUGE_LINGER: cfg_ff.gauge_linger_ticks <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req.ready) begin
         in_vld_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_level_ff <= req.switch_level;
         in_knob_ff  <= req.knob_turned;
      end
   end

   bgc_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .switch_level (in_level_ff),
      .knob_turned  (in_knob_ff),
      .cfg          (cfg_ff),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp.valid              = out_vld_ff;
   assign rsp.transport_action   = out_ff.transport_action;
   assign rsp.mute_toggled       = out_ff.mute_toggled;
   assign rsp.gauge_read_request = out_ff.gauge_read_request;
   assign rsp.activity           = out_ff.activity;
   assign rsp.muted              = out_ff.muted;
   assign rsp.playing            = out_ff.playing;
   assign rsp.gauge_shown        = out_ff.gauge_shown;
   assign rsp.pressed            = out_ff.pressed;

   a_request_held: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && out_vld_ff && !rsp.ready |=> in_vld_ff && $stable(in_level_ff))
      else $error("pending request lost during result stall");

   a_gauge_request_pressed: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.gauge_read_request |-> rsp.pressed && rsp.activity)
      else $error("gauge read request without a held switch");

   a_dispatch_released: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.transport_action != ACT_NONE |-> !rsp.pressed)
      else $error("click dispatch while switch held");

   a_toggle_released: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.mute_toggled |-> !rsp.pressed)
      else $error("mute toggle while switch held");

endmodule

// ----- tb/gesture_result_checker.sv -----
// ----------------------------------------------------------------------------
// gesture_result_checker: tick predictor and result scoreboard
// Watches the request, result and timing-register ports of the gesture
// classifier. Each accepted request is run through a cycle-free model of the
// debounce, hold and click logic. The expected result is queued, and every
// accepted result is compared field by field against the oldest entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gesture_result_checker
   import bgc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   bgc_req_if                   req,
   bgc_rsp_if                   rsp,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output int unsigned          in_flight,
   output int unsigned          error_count
);

   cfg_type               timing;
   logic                  raw_prev;
   logic                  level_now;
   logic [TIMER_BITS-1:0] since_edge;
   logic [TIMER_BITS-1:0] since_down;
   logic [TIMER_BITS-1:0] since_tap;
   logic [1:0]            taps;
   logic                  gauge_set;
   logic [CFG_W-1:0]      linger_left;
   logic                  mute_on;
   logic                  play_on;
   result_type            predicted_results[$];

   initial begin
      error_count = 0;
      in_flight   = 0;
   end

   function automatic logic [TIMER_BITS-1:0] bump(input logic [TIMER_BITS-1:0] t);
      return (t == TIMER_MAX) ? t : t + 1'b1;
   endfunction

   task automatic restore_defaults();
      timing.debounce_ticks     = RST_DEBOUNCE;
      timing.click_gap_ticks    = RST_CLICK_GAP;
      timing.long_press_ticks   = RST_LONG_PRESS;
      timing.gauge_hold_ticks   = RST_GAUGE_HOLD;
      timing.gauge_linger_ticks = RST_GAUGE_LINGER;
      raw_prev    = 1'b1;
      level_now   = 1'b1;
      since_edge  = '0;
      since_down  = '0;
      since_tap   = '0;
      taps        = '0;
      gauge_set   = 1'b0;
      linger_left = '0;
      mute_on     = 1'b0;
      play_on     = 1'b0;
   endtask

   task automatic classify_tick(input logic lvl, input logic turn, output result_type r);
      r = '0;
      since_edge = bump(since_edge);
      since_down = bump(since_down);
      since_tap  = bump(since_tap);
      if (linger_left != 0) begin
         linger_left = linger_left - 1'b1;
      end

      if (turn) begin
         r.activity = 1'b1;
         mute_on    = 1'b0;
      end

      if (lvl != raw_prev) begin
         raw_prev   = lvl;
         since_edge = '0;
      end

      if (since_edge > timing.debounce_ticks && lvl != level_now) begin
         level_now = lvl;
         if (!level_now) begin
            r.activity = 1'b1;
            since_down = '0;
            gauge_set  = 1'b0;
         end else if (!gauge_set) begin
            if (since_down >= timing.long_press_ticks) begin
               mute_on        = ~mute_on;
               r.mute_toggled = 1'b1;
            end else begin
               if (taps != CLICKS_MAX) begin
                  taps = taps + 1'b1;
               end
               since_tap = '0;
            end
         end
      end

      if (!level_now && since_down >= timing.gauge_hold_ticks) begin
         if (!gauge_set) begin
            gauge_set            = 1'b1;
            r.gauge_read_request = 1'b1;
         end
         linger_left = timing.gauge_linger_ticks;
         r.activity  = 1'b1;
      end

      if (taps != 0 && level_now && since_tap > timing.click_gap_ticks) begin
         case (taps)
            2'd1: begin
               play_on            = ~play_on;
               r.transport_action = ACT_PLAY;
            end
            2'd2: r.transport_action = ACT_NEXT;
            default: r.transport_action = ACT_PREV;
         endcase
         taps = '0;
      end

      r.muted       = mute_on;
      r.playing     = play_on;
      r.gauge_shown = (linger_left != 0);
      r.pressed     = !level_now;
   endtask

   task automatic note_field(input string name, input int unsigned want,
                             input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      result_type tick_result;
      if (reset) begin
         restore_defaults();
         predicted_results.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (predicted_results.size() == 0) begin
               $display("%0t: result with no request pending, expected none actual %h",
                        $time, {rsp.transport_action, rsp.mute_toggled,
                                rsp.gauge_read_request, rsp.activity, rsp.muted,
                                rsp.playing, rsp.gauge_shown, rsp.pressed});
               error_count++;
            end else begin
               want = predicted_results.pop_front();
               note_field("transport_action", want.transport_action, rsp.transport_action);
               note_field("mute_toggled", want.mute_toggled, rsp.mute_toggled);
               note_field("gauge_read_request", want.gauge_read_request,
                          rsp.gauge_read_request);
               note_field("activity", want.activity, rsp.activity);
               note_field("muted", want.muted, rsp.muted);
               note_field("playing", want.playing, rsp.playing);
               note_field("gauge_shown", want.gauge_shown, rsp.gauge_shown);
               note_field("pressed", want.pressed, rsp.pressed);
            end
         end
         if (req.valid && req.ready) begin
            classify_tick(req.switch_level, req.knob_turned, tick_result);
            predicted_results.push_back(tick_result);
         end
         if (csr_wr_en) begin
            case (csr_index)
               REG_DEBOUNCE:     timing.debounce_ticks     = csr_wdata;
               REG_CLICK_GAP:    timing.click_gap_ticks    = csr_wdata;
               REG_LONG_PRESS:   timing.long_press_ticks   = csr_wdata;
               REG_GAUGE_HOLD:   timing.gauge_hold_ticks   = csr_wdata;
               REG_GAUGE_LINGER: timing.gauge_linger_ticks = csr_wdata;
               default: ;
            endcase
         end
      end
      in_flight = predicted_results.size();
   end

endmodule

// ----- tb/button_gesture_classifier_unit_test.sv -----
// ----------------------------------------------------------------------------
// button_gesture_classifier_unit_test: top-level testbench
// Drives tick requests and timing-register writes into the classifier:
// directed taps, multi-clicks, long and gauge holds, knob turns and extreme
// timings at full scale, then random gesture streams under
// several sender and receiver stall patterns. Checking is in the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_gesture_classifier_unit_test;
   import bgc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 3'd7;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;
   int unsigned          in_flight;
   int unsigned          error_count;
   int unsigned          cycle_count = 0;
   int unsigned          items_sent = 0;
   int unsigned          req_idle_pct = 0;
   int unsigned          rsp_stall_pct = 0;
   int unsigned          turn_pct = 0;
   int unsigned          deb_t, gap_t, long_t, hold_t, linger_t;

   bgc_req_if req_ch ();
   bgc_rsp_if rsp_ch ();

   button_gesture_classifier_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   gesture_result_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .in_flight   (in_flight),
      .error_count (error_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, in_flight);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   task automatic send_tick(input logic lvl, input logic turn);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.switch_level <= lvl;
      req_ch.knob_turned  <= turn;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic hold_level(input logic lvl, input int unsigned n);
      repeat (n) send_tick(lvl, $urandom_range(0, 99) < turn_pct);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   task automatic set_timings(input int unsigned deb, input int unsigned gap,
                              input int unsigned lng, input int unsigned hld,
                              input int unsigned lin);
      deb_t    = deb;
      gap_t    = gap;
      long_t   = lng;
      hold_t   = hld;
      linger_t = lin;
      write_reg(REG_DEBOUNCE, CFG_W'(deb));
      write_reg(REG_CLICK_GAP, CFG_W'(gap));
      write_reg(REG_LONG_PRESS, CFG_W'(lng));
      write_reg(REG_GAUGE_HOLD, CFG_W'(hld));
      write_reg(REG_GAUGE_LINGER, CFG_W'(lin));
      // unmapped index must leave every timing untouched
      write_reg(REG_SPARE, CFG_W'($urandom_range(0, 16'hFFFF)));
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (in_flight != 0) @(negedge clock);
   endtask

   task automatic random_timings();
      int unsigned lng;
      int unsigned hld;
      lng = $urandom_range(1, 8);
      hld = ($urandom_range(0, 3) == 0) ? $urandom_range(0, lng) : lng + $urandom_range(1, 8);
      set_timings($urandom_range(0, 2), $urandom_range(0, 6), lng, hld,
                  $urandom_range(0, 8));
   endtask

   task automatic run_gestures(input int unsigned n);
      int unsigned start;
      start = items_sent;
      while (items_sent - start < n) begin
         case ($urandom_range(0, 5))
            0, 1: begin
               hold_level(1'b0, deb_t + 1 + $urandom_range(0, long_t));
               hold_level(1'b1, deb_t + 1 + $urandom_range(0, gap_t + 2));
            end
            2: begin
               hold_level(1'b0, deb_t + 1 + long_t +
                          $urandom_range(0, (hold_t > long_t) ? hold_t - long_t : 2));
               hold_level(1'b1, deb_t + 1 + $urandom_range(0, gap_t + 2));
            end
            3: begin
               hold_level(1'b0, deb_t + 1 + hold_t + $urandom_range(0, 3));
               hold_level(1'b1, deb_t + 1 + $urandom_range(0, linger_t + 2));
            end
            4: hold_level(1'b1, $urandom_range(1, deb_t + gap_t + 4));
            default: begin
               // contact bounce
               repeat ($urandom_range(1, 6)) begin
                  send_tick($urandom_range(0, 1) == 1, $urandom_range(0, 3) == 0);
               end
            end
         endcase
      end
   endtask

   initial begin
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_index           = REG_DEBOUNCE;
      csr_wdata           = '0;
      req_ch.valid        = 1'b0;
      req_ch.switch_level = 1'b1;
      req_ch.knob_turned  = 1'b0;
      rsp_ch.ready        = 1'b0;
      deb_t               = RST_DEBOUNCE;
      gap_t               = RST_CLICK_GAP;
      long_t              = RST_LONG_PRESS;
      hold_t              = RST_GAUGE_HOLD;
      linger_t            = RST_GAUGE_LINGER;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // reset timings: a short press never settles
      hold_level(1'b0, 3);
      hold_level(1'b1, 2);
      drain();

      // four taps saturate the click count, then medium hold, turn, gauge hold
      set_timings(0, 2, 3, 5, 1);
      repeat (4) begin
         hold_level(1'b0, 2);
         hold_level(1'b1, 2);
      end
      hold_level(1'b1, 2);
      hold_level(1'b0, 5);
      hold_level(1'b1, 2);
      send_tick(1'b1, 1'b1);
      hold_level(1'b0, 7);
      hold_level(1'b1, 3);
      drain();

      // gauge arms on the press itself
      set_timings(0, 1, 1, 0, 3);
      hold_level(1'b0, 3);
      hold_level(1'b1, 3);
      drain();

      // debounce at full scale: no level is ever taken
      set_timings(16'hFFFF, 1, 2, 4, 2);
      hold_level(1'b0, 4);
      hold_level(1'b1, 2);
      send_tick(1'b1, 1'b1);
      drain();

      // full-scale holds and gap: short presses tap and the taps wait for their gap
      set_timings(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      hold_level(1'b0, 6);
      hold_level(1'b1, 3);
      hold_level(1'b0, 2);
      hold_level(1'b1, 3);
      drain();

      turn_pct = 6;
      for (int mode = 0; mode < 4; mode++) begin
         case (mode)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 83; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 83; end
            default: begin req_idle_pct = 7; rsp_stall_pct = 7; end
         endcase
         random_timings();
         run_gestures(100);
         drain();
      end

      repeat (8) @(negedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/bgc_pkg.sv
src/bgc_if.sv
src/bgc_core.sv
src/button_gesture_classifier_unit.sv
tb/gesture_result_checker.sv
tb/button_gesture_classifier_unit_test.sv
